/* hw/rtl/pcgmix_pkg.sv */
// Types, constants, microcode table and output permutation for the PCG32 generator.
package pcgmix_pkg;

  localparam int unsigned StepW = 5;
  typedef logic [StepW-1:0] step_t;

  typedef enum logic [2:0] {
    OP_IDLE = 3'd0,
    OP_OUT  = 3'd1,
    OP_LOAD = 3'd2,
    OP_XS   = 3'd3,
    OP_MUL0 = 3'd4,
    OP_MUL1 = 3'd5,
    OP_MUL2 = 3'd6,
    OP_ADD  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    K_MIXA = 2'd0,
    K_MIXB = 2'd1,
    K_LCG  = 2'd2
  } ksel_t;

  typedef enum logic [1:0] {
    SH_30 = 2'd0,
    SH_27 = 2'd1,
    SH_31 = 2'd2
  } shsel_t;

  typedef enum logic {
    AD_GOLDEN = 1'b0,
    AD_INC    = 1'b1
  } asel_t;

  typedef struct packed {
    op_t    op;
    ksel_t  ksel;
    shsel_t shsel;
    asel_t  asel;
    logic   store;
    logic   last;
  } ctrl_t;

  localparam logic [63:0] GOLDEN    = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] LCG_MUL   = 64'd6364136223846793005;
  localparam logic [63:0] LCG_INC   = 64'd1442695040888963407;
  localparam logic [63:0] MIX_MUL_A = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B = 64'h94D049BB133111EB;

  localparam step_t StepIdle   = step_t'(0);
  localparam step_t StepDraw   = step_t'(1);
  localparam step_t StepReseed = step_t'(6);

  function automatic ctrl_t cw(op_t op, ksel_t k, shsel_t sh, asel_t a,
                               logic st, logic last);
    ctrl_t c;
    c.op    = op;
    c.ksel  = k;
    c.shsel = sh;
    c.asel  = a;
    c.store = st;
    c.last  = last;
    return c;
  endfunction

  // Microcode: draw at 1..5, reseed at 6..24.
  // A 64-bit product mod 2^64 takes three 32x32 steps (lo*lo, lo*hi, hi*lo).
  function automatic ctrl_t ucode(step_t pc);
    ctrl_t c;
    case (pc)
      5'd0:    c = cw(OP_IDLE, K_LCG,  SH_30, AD_INC,    1'b0, 1'b0);
      5'd1:    c = cw(OP_OUT,  K_LCG,  SH_30, AD_INC,    1'b0, 1'b0);
      5'd2:    c = cw(OP_MUL0, K_LCG,  SH_30, AD_INC,    1'b0, 1'b0);
      5'd3:    c = cw(OP_MUL1, K_LCG,  SH_30, AD_INC,    1'b0, 1'b0);
      5'd4:    c = cw(OP_MUL2, K_LCG,  SH_30, AD_INC,    1'b0, 1'b0);
      5'd5:    c = cw(OP_ADD,  K_LCG,  SH_30, AD_INC,    1'b1, 1'b1);
      5'd6:    c = cw(OP_LOAD, K_MIXA, SH_30, AD_INC,    1'b0, 1'b0);
      5'd7:    c = cw(OP_XS,   K_MIXA, SH_30, AD_INC,    1'b0, 1'b0);
      5'd8:    c = cw(OP_MUL0, K_MIXA, SH_30, AD_INC,    1'b0, 1'b0);
      5'd9:    c = cw(OP_MUL1, K_MIXA, SH_30, AD_INC,    1'b0, 1'b0);
      5'd10:   c = cw(OP_MUL2, K_MIXA, SH_30, AD_INC,    1'b0, 1'b0);
      5'd11:   c = cw(OP_XS,   K_MIXB, SH_27, AD_INC,    1'b0, 1'b0);
      5'd12:   c = cw(OP_MUL0, K_MIXB, SH_27, AD_INC,    1'b0, 1'b0);
      5'd13:   c = cw(OP_MUL1, K_MIXB, SH_27, AD_INC,    1'b0, 1'b0);
      5'd14:   c = cw(OP_MUL2, K_MIXB, SH_27, AD_INC,    1'b0, 1'b0);
      5'd15:   c = cw(OP_XS,   K_LCG,  SH_31, AD_INC,    1'b0, 1'b0);
      5'd16:   c = cw(OP_ADD,  K_LCG,  SH_31, AD_GOLDEN, 1'b0, 1'b0);
      5'd17:   c = cw(OP_MUL0, K_LCG,  SH_31, AD_INC,    1'b0, 1'b0);
      5'd18:   c = cw(OP_MUL1, K_LCG,  SH_31, AD_INC,    1'b0, 1'b0);
      5'd19:   c = cw(OP_MUL2, K_LCG,  SH_31, AD_INC,    1'b0, 1'b0);
      5'd20:   c = cw(OP_ADD,  K_LCG,  SH_31, AD_INC,    1'b0, 1'b0);
      5'd21:   c = cw(OP_MUL0, K_LCG,  SH_31, AD_INC,    1'b0, 1'b0);
      5'd22:   c = cw(OP_MUL1, K_LCG,  SH_31, AD_INC,    1'b0, 1'b0);
      5'd23:   c = cw(OP_MUL2, K_LCG,  SH_31, AD_INC,    1'b0, 1'b0);
      5'd24:   c = cw(OP_ADD,  K_LCG,  SH_31, AD_INC,    1'b1, 1'b1);
      default: c = cw(OP_IDLE, K_LCG,  SH_30, AD_INC,    1'b0, 1'b1);
    endcase
    return c;
  endfunction

  // XSH-RR: xorshift high, then rotate right by the top five bits.
  function automatic logic [31:0] permute(logic [63:0] x);
    logic [63:0] t;
    logic [31:0] w;
    logic [4:0]  r;
    logic [63:0] rot;
    t   = ((x >> 18) ^ x) >> 27;
    w   = t[31:0];
    r   = x[63:59];
    rot = {w, w} >> r;
    return rot[31:0];
  endfunction

endpackage

/* hw/rtl/pcgmix_dp.sv */
// Datapath: generator state, work registers and a shared 32x32 multiplier.
module pcgmix_dp (
  input  logic               clk,
  input  logic               rst,
  input  pcgmix_pkg::ctrl_t  ctl,
  input  logic               load_keys,
  input  logic [31:0]        seed_high,
  input  logic [31:0]        seed_low,
  output logic [31:0]        word
);
  import pcgmix_pkg::*;

  logic [63:0] state;
  logic [63:0] z;
  logic [63:0] p;
  logic [31:0] key_hi;
  logic [31:0] key_lo;

  logic [63:0] kval;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [4:0]  shamt;
  logic [63:0] xs;
  logic [63:0] addend;
  logic [63:0] sum;

  always_comb begin
    case (ctl.ksel)
      K_MIXA:  kval = MIX_MUL_A;
      K_MIXB:  kval = MIX_MUL_B;
      K_LCG:   kval = LCG_MUL;
      default: kval = LCG_MUL;
    endcase
    case (ctl.shsel)
      SH_30:   shamt = 5'd30;
      SH_27:   shamt = 5'd27;
      SH_31:   shamt = 5'd31;
      default: shamt = 5'd31;
    endcase
    mul_a  = (ctl.op == OP_MUL2) ? z[63:32] : z[31:0];
    mul_b  = (ctl.op == OP_MUL1) ? kval[63:32] : kval[31:0];
    prod   = {32'd0, mul_a} * {32'd0, mul_b};
    xs     = p ^ (p >> shamt);
    addend = (ctl.asel == AD_GOLDEN) ? GOLDEN : LCG_INC;
    sum    = p + addend;
  end

  always_ff @(posedge clk) begin
    if (load_keys) begin
      key_hi <= seed_high;
      key_lo <= seed_low;
    end
    case (ctl.op)
      OP_OUT:  z <= state;
      OP_LOAD: p <= {key_hi, 32'd0} ^ ({32'd0, key_lo} + GOLDEN);
      OP_XS: begin
        z <= xs;
        p <= xs;
      end
      OP_MUL0: p <= prod;
      OP_MUL1: p[63:32] <= p[63:32] + prod[31:0];
      OP_MUL2: p[63:32] <= p[63:32] + prod[31:0];
      OP_ADD:  z <= sum;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= 64'd0;
    end else if (ctl.op == OP_ADD && ctl.store) begin
      state <= sum;
    end
  end

  assign word = permute(state);

endmodule

/* hw/rtl/pcg_random_with_mixed_seed.sv */
// PCG32 XSH-RR generator with SplitMix64 key mixing, run by a microcode sequencer.
// Draw: registers the current state's word, held while the output stalls, then steps the LCG state.
// Reseed: no output word. Either command keeps cmd_stall high until the sequencer is idle again.
// Rate is set by the single 32x32 multiplier: each 64-bit multiply takes three steps.
// Reset (synchronous, rst high) clears the state to zero and returns the sequencer to idle.
module pcg_random_with_mixed_seed (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic        cmd,
  input  logic [31:0] seed_high,
  input  logic [31:0] seed_low,
  output logic        word_valid,
  input  logic        word_stall,
  output logic [31:0] random_word
);
  import pcgmix_pkg::*;

  step_t       pc;
  step_t       pc_next;
  ctrl_t       ctl;
  logic        accept;
  logic        out_free;
  logic [31:0] perm_word;

  assign ctl       = ucode(pc);
  assign cmd_stall = (ctl.op != OP_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !word_valid || !word_stall;

  always_comb begin
    pc_next = pc;
    case (ctl.op)
      OP_IDLE: begin
        if (accept) begin
          pc_next = cmd ? StepReseed : StepDraw;
        end
      end
      // hold until the output register can take the word
      OP_OUT: begin
        if (out_free) begin
          pc_next = pc + step_t'(1);
        end
      end
      default: begin
        pc_next = ctl.last ? StepIdle : pc + step_t'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= StepIdle;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (ctl.op == OP_OUT && out_free) begin
      word_valid <= 1'b1;
    end else if (!word_stall) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_OUT && out_free) begin
      random_word <= perm_word;
    end
  end

  pcgmix_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .load_keys (accept),
    .seed_high (seed_high),
    .seed_low  (seed_low),
    .word      (perm_word)
  );

endmodule
